// ===== rtl/core/oaht_pkg.sv =====
// Shared types and constants for the open-addressing hash table core.
`default_nettype none

package oaht_pkg;

	// Fixed field widths of one request and one response word.
	localparam int KEY_W   = 32;
	localparam int HASH_W  = 32;
	localparam int VALUE_W = 64;

	// Request operation codes.
	typedef enum logic [1:0] {
		REQ_GET   = 2'd0,
		REQ_SET   = 2'd1,
		REQ_DEL   = 2'd2,
		REQ_CLEAR = 2'd3
	} req_op_t;

	// Per-slot occupancy code.
	typedef enum logic [1:0] {
		SLOT_EMPTY = 2'd0,
		SLOT_USED  = 2'd1,
		SLOT_TOMB  = 2'd2
	} slot_state_t;

	// Response status codes.
	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_MISS = 2'd1,
		ST_FULL = 2'd2
	} rsp_status_t;

	// Control sequencer states.
	typedef enum logic [2:0] {
		FSM_INIT,
		FSM_IDLE,
		FSM_MOD,
		FSM_READ,
		FSM_PROBE,
		FSM_CLEAR,
		FSM_DONE
	} fsm_t;

	// One table slot as held in the slot memory.
	typedef struct packed {
		slot_state_t               state;
		logic [KEY_W-1:0]   key;
		logic [VALUE_W-1:0] value;
	} slot_entry_t;

endpackage

`default_nettype wire

// ===== rtl/core/open_addressing_hash_table_core.sv =====
// Top level of the linear-probing hash table with tombstones and a slot memory.
//
// The table keeps CAPACITY slots (state, key, value) in one synchronous memory with a
// write port and a read port, and handles one request word at a time. A get, set or
// delete whose key sits in its home slot passes through memory read, compare and
// write-back, and response, and the core can take the next request while that response
// word is offered. Every further slot the probe visits adds one more memory read, since
// the slot memory gives one read per cycle. When CAPACITY is not a power of two the home
// slot comes from a reciprocal multiplication of the hash followed by one correcting
// subtraction, which adds a quotient, remainder and correction step to each request.
// A clear sweeps the slot memory one entry per cycle. After reset the same sweep runs
// over every slot with req_stall high. A set of a new key that would push the used count
// (occupied slots plus tombstones) past three quarters of CAPACITY, and that finds no
// tombstone to reuse, is refused with the full status. A new request is taken while the
// previous response word still waits on rsp_stall.
`default_nettype none

module open_addressing_hash_table_core #(
	parameter int CAPACITY = 256
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// Request channel
	input  logic                          req_valid,
	output logic                          req_stall,
	input  logic [1:0]                    req_type,
	input  logic [oaht_pkg::KEY_W-1:0]   key_id,
	input  logic [oaht_pkg::HASH_W-1:0]  key_hash,
	input  logic [oaht_pkg::VALUE_W-1:0] write_value,
	// Response channel
	output logic                          rsp_valid,
	input  logic                          rsp_stall,
	output logic [1:0]                    status,
	output logic                          new_key,
	output logic [oaht_pkg::VALUE_W-1:0] read_value
);

	import oaht_pkg::*;

	localparam int IDX_W = $clog2(CAPACITY);
	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int MOD_W = 2;
	localparam bit IS_POW2 = (CAPACITY & (CAPACITY - 1)) == 0;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);
	localparam logic [MOD_W-1:0] LAST_PHASE = MOD_W'(2);
	localparam logic [CNT_W+1:0] LIMIT = (CNT_W + 2)'(3 * CAPACITY);
	localparam logic [HASH_W-1:0] RECIP = HASH_W'((64'd1 << HASH_W) / CAPACITY);
	localparam logic [HASH_W-1:0] CAP_H = HASH_W'(CAPACITY);

	// Slot memory
	slot_entry_t mem [CAPACITY];
	slot_entry_t mem_rdata_q;
	logic        mem_we;
	logic [IDX_W-1:0] mem_waddr;
	slot_entry_t mem_wdata;
	logic [IDX_W-1:0] rd_addr;

	// Sequencer and request registers
	fsm_t state_q, state_d;
	req_op_t op_q;
	logic [KEY_W-1:0]   key_q;
	logic [HASH_W-1:0]  hash_q;
	logic [HASH_W-1:0]  quot_q;
	logic [VALUE_W-1:0] wval_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   step_q;
	logic [IDX_W-1:0]   tomb_q;
	logic               tomb_seen_q;
	logic [MOD_W-1:0]   modcnt_q;
	logic [IDX_W-1:0]   clr_q;
	logic [CNT_W-1:0]   used_q;

	// Result waiting for the output register
	rsp_status_t        res_status_q;
	logic               res_new_q;
	logic [VALUE_W-1:0] res_val_q;

	// Output register
	logic               rsp_valid_q;
	rsp_status_t        status_q;
	logic               new_key_q;
	logic [VALUE_W-1:0] read_value_q;

	// Combinational control
	logic               accept;
	logic               finish;
	rsp_status_t        fin_status;
	logic               fin_new;
	logic [VALUE_W-1:0] fin_val;
	logic               cnt_inc;
	logic               cnt_clr;
	logic               advance;
	logic               rsp_load;
	logic [IDX_W-1:0]   idx_next;
	logic [2*HASH_W-1:0] mod_prod;
	logic [HASH_W-1:0]  mod_rem;
	logic [IDX_W-1:0]   mod_idx;
	logic               is_hit;
	logic               tomb_seen_n;
	logic [IDX_W-1:0]   tomb_n;
	logic               have_free;
	logic [IDX_W-1:0]   free_addr;
	logic [CNT_W-1:0]   used_p1;
	logic               over_limit;

	assign accept = req_valid && !req_stall;

	// Next slot in probe order, wrapping at the end of the table.
	assign idx_next = (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;

	// Hash remainder by reciprocal multiplication. The quotient estimate is low by at
	// most one, so the remainder estimate is below twice CAPACITY and one subtraction
	// corrects it. After the second phase hash_q holds the remainder estimate.
	assign mod_prod = (2*HASH_W)'(hash_q) * (2*HASH_W)'(RECIP);
	assign mod_rem  = hash_q - quot_q * CAP_H;
	assign mod_idx  = (hash_q >= CAP_H) ? IDX_W'(hash_q - CAP_H) : IDX_W'(hash_q);

	// Probe bookkeeping on the slot just read.
	assign is_hit = (mem_rdata_q.state == SLOT_USED) && (mem_rdata_q.key == key_q);
	assign tomb_seen_n = tomb_seen_q || (mem_rdata_q.state == SLOT_TOMB);
	assign tomb_n = tomb_seen_q ? tomb_q : idx_q;
	assign have_free = (mem_rdata_q.state == SLOT_EMPTY) || tomb_seen_n;
	assign free_addr = tomb_seen_n ? tomb_n : idx_q;

	// Load limit for a new key taking an empty slot.
	assign used_p1 = used_q + 1'b1;
	assign over_limit = {used_p1, 2'b00} > LIMIT;

	// Next state, memory access and result selection.
	always_comb begin
		state_d    = state_q;
		req_stall  = 1'b1;
		rd_addr    = idx_q;
		mem_we     = 1'b0;
		mem_waddr  = idx_q;
		mem_wdata  = '{state: SLOT_EMPTY, key: key_q, value: wval_q};
		finish     = 1'b0;
		fin_status = ST_OK;
		fin_new    = 1'b0;
		fin_val    = '0;
		cnt_inc    = 1'b0;
		cnt_clr    = 1'b0;
		advance    = 1'b0;
		rsp_load   = 1'b0;
		case (state_q)
			FSM_INIT: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_IDX) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					if (req_type == REQ_CLEAR) begin
						state_d = FSM_CLEAR;
					end else if (IS_POW2) begin
						state_d = FSM_READ;
					end else begin
						state_d = FSM_MOD;
					end
				end
			end
			FSM_MOD: begin
				if (modcnt_q == LAST_PHASE) begin
					state_d = FSM_READ;
				end
			end
			FSM_READ: begin
				rd_addr = idx_q;
				state_d = FSM_PROBE;
			end
			FSM_PROBE: begin
				if (is_hit) begin
					// Key present at this slot.
					finish = 1'b1;
					case (op_q)
						REQ_GET: begin
							fin_val = mem_rdata_q.value;
						end
						REQ_SET: begin
							mem_we    = 1'b1;
							mem_wdata = '{state: SLOT_USED, key: key_q, value: wval_q};
						end
						REQ_DEL: begin
							mem_we    = 1'b1;
							mem_wdata = '{state: SLOT_TOMB, key: mem_rdata_q.key,
								value: mem_rdata_q.value};
						end
						default: ;
					endcase
				end else if (mem_rdata_q.state == SLOT_EMPTY || step_q == LAST_IDX) begin
					// Probe ended without the key.
					finish = 1'b1;
					case (op_q)
						REQ_SET: begin
							if (tomb_seen_n) begin
								mem_we    = 1'b1;
								mem_waddr = free_addr;
								mem_wdata = '{state: SLOT_USED, key: key_q, value: wval_q};
								fin_new   = 1'b1;
							end else if (!have_free || over_limit) begin
								fin_status = ST_FULL;
							end else begin
								mem_we    = 1'b1;
								mem_waddr = free_addr;
								mem_wdata = '{state: SLOT_USED, key: key_q, value: wval_q};
								fin_new   = 1'b1;
								cnt_inc   = 1'b1;
							end
						end
						default: begin
							fin_status = ST_MISS;
						end
					endcase
				end else begin
					// Move on and read the next slot right away.
					advance = 1'b1;
					rd_addr = idx_next;
				end
				if (finish) begin
					state_d = FSM_DONE;
				end
			end
			FSM_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == LAST_IDX) begin
					cnt_clr = 1'b1;
					finish  = 1'b1;
					state_d = FSM_DONE;
				end
			end
			FSM_DONE: begin
				if (!rsp_valid_q || !rsp_stall) begin
					rsp_load = 1'b1;
					state_d  = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// Control counters and response valid.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q      <= '0;
			clr_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cnt_clr) begin
				used_q <= '0;
			end else if (cnt_inc) begin
				used_q <= used_p1;
			end
			if (state_q == FSM_INIT || state_q == FSM_CLEAR) begin
				clr_q <= (clr_q == LAST_IDX) ? '0 : clr_q + 1'b1;
			end
			if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end
		end
	end

	// Request, probe and result registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q        <= req_op_t'(req_type);
			key_q       <= key_id;
			hash_q      <= key_hash;
			wval_q      <= write_value;
			idx_q       <= IS_POW2 ? key_hash[IDX_W-1:0] : '0;
			step_q      <= '0;
			tomb_seen_q <= 1'b0;
			tomb_q      <= '0;
			modcnt_q    <= '0;
		end
		// The first phase estimates the quotient, the second forms the remainder
		// estimate and the third corrects it into the home slot.
		if (state_q == FSM_MOD) begin
			if (modcnt_q == '0) begin
				quot_q <= mod_prod[2*HASH_W-1:HASH_W];
			end else if (modcnt_q == MOD_W'(1)) begin
				hash_q <= mod_rem;
			end else begin
				idx_q <= mod_idx;
			end
			modcnt_q <= modcnt_q + 1'b1;
		end
		if (advance) begin
			idx_q       <= idx_next;
			step_q      <= step_q + 1'b1;
			tomb_seen_q <= tomb_seen_n;
			tomb_q      <= tomb_n;
		end
		if (finish) begin
			res_status_q <= fin_status;
			res_new_q    <= fin_new;
			res_val_q    <= fin_val;
		end
		if (rsp_load) begin
			status_q     <= res_status_q;
			new_key_q    <= res_new_q;
			read_value_q <= res_val_q;
		end
	end

	// Slot memory: one write and one registered read per cycle.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		mem_rdata_q <= mem[rd_addr];
	end

	assign rsp_valid  = rsp_valid_q;
	assign status     = status_q;
	assign new_key    = new_key_q;
	assign read_value = read_value_q;

	// The used count never passes the load limit.
	assert property (@(posedge clk) disable iff (!arst_n)
		used_q <= CNT_W'((3 * CAPACITY) / 4))
	else $error("used count above load limit");

	// The slot memory is never written while waiting for or finishing a request.
	assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> (state_q != FSM_IDLE && state_q != FSM_DONE))
	else $error("slot write outside a sweep or probe");

	// A refused set returns no new key and a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && status == ST_FULL) |-> (!new_key && read_value == '0))
	else $error("full status with nonzero payload");

	// An accepted clear starts the clearing sweep.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && req_type == REQ_CLEAR) |=> (state_q == FSM_CLEAR && clr_q == '0))
	else $error("clear did not start the sweep");

	// A probe step always follows a memory read issue or another probe step.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == FSM_PROBE) |-> ($past(state_q) == FSM_READ || $past(state_q) == FSM_PROBE))
	else $error("probe without a read issued");

endmodule

`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the open-addressing hash table core.
`timescale 1ns / 1ps

module testbench;
	import oaht_pkg::*;

	localparam int CAPACITY       = 256;
	localparam int LOAD_LIMIT     = CAPACITY * 3 / 4;
	localparam int POOL_SIZE      = 320;
	localparam int HOLD_CYCLES    = 400;
	localparam int DRAIN_CYCLES   = 2 * CAPACITY + 20;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int PHASE_WORDS    = 320;

	// One response word as the table should produce it.
	typedef struct packed {
		rsp_status_t         status;
		logic                new_key;
		logic [VALUE_W-1:0]  read_value;
	} rsp_word_t;

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                req_valid   = 1'b0;
	logic                req_stall;
	logic [1:0]          req_type    = REQ_GET;
	logic [KEY_W-1:0]    key_id      = '0;
	logic [HASH_W-1:0]   key_hash    = '0;
	logic [VALUE_W-1:0]  write_value = '0;
	logic                rsp_valid;
	logic                rsp_stall   = 1'b0;
	logic [1:0]          status;
	logic                new_key;
	logic [VALUE_W-1:0]  read_value;

	// Mirror of the table contents, advanced once per accepted request word.
	slot_state_t         tbl_state [CAPACITY];
	logic [KEY_W-1:0]    tbl_key   [CAPACITY];
	logic [VALUE_W-1:0]  tbl_value [CAPACITY];
	int                  tbl_used;

	// Response words owed by the table, oldest first.
	rsp_word_t           rsp_owed [$];

	// Keys reused across requests so that hits, tombstones and long probes happen.
	logic [KEY_W-1:0]    pool_key  [POOL_SIZE];
	logic [HASH_W-1:0]   pool_hash [POOL_SIZE];

	int                  req_idle_pct  = 0;
	int                  rsp_stall_pct = 0;
	logic                hold_trigger  = 1'b0;
	int                  hold_left     = 0;
	int                  quiet_cycles  = 0;
	int                  errors        = 0;

	open_addressing_hash_table_core #(
		.CAPACITY(CAPACITY)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_type(req_type),
		.key_id(key_id),
		.key_hash(key_hash),
		.write_value(write_value),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.status(status),
		.new_key(new_key),
		.read_value(read_value)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Empties every slot of the mirror, as reset and a clear request do.
	function automatic void empty_table();
		foreach (tbl_state[i]) tbl_state[i] = SLOT_EMPTY;
		tbl_used = 0;
	endfunction

	// Applies one request to the mirror and returns the response word it earns.
	function automatic rsp_word_t apply_to_table(req_op_t op, logic [KEY_W-1:0] key,
			logic [HASH_W-1:0] hash, logic [VALUE_W-1:0] wval);
		rsp_word_t rsp;
		int        idx;
		int        hit;
		int        free_idx;
		int        tomb_idx;
		bit        found;
		bit        have_free;
		bit        tomb_seen;

		rsp = '{ST_OK, 1'b0, '0};
		if (op == REQ_CLEAR) begin
			empty_table();
			return rsp;
		end

		// Linear probe from the home slot until a match or an empty slot.
		idx = int'(hash % CAPACITY);
		hit = 0;
		free_idx = 0;
		tomb_idx = 0;
		found = 1'b0;
		have_free = 1'b0;
		tomb_seen = 1'b0;
		for (int n = 0; n < CAPACITY && !found && !have_free; n++) begin
			if (tbl_state[idx] == SLOT_USED && tbl_key[idx] == key) begin
				found = 1'b1;
				hit = idx;
			end else if (tbl_state[idx] == SLOT_EMPTY) begin
				have_free = 1'b1;
				free_idx = tomb_seen ? tomb_idx : idx;
			end else begin
				if (tbl_state[idx] == SLOT_TOMB && !tomb_seen) begin
					tomb_seen = 1'b1;
					tomb_idx = idx;
				end
				idx = (idx + 1) % CAPACITY;
			end
		end
		if (!found && !have_free && tomb_seen) begin
			have_free = 1'b1;
			free_idx = tomb_idx;
		end

		case (op)
			REQ_GET: begin
				if (found) rsp.read_value = tbl_value[hit];
				else rsp.status = ST_MISS;
			end
			REQ_DEL: begin
				if (found) tbl_state[hit] = SLOT_TOMB;
				else rsp.status = ST_MISS;
			end
			default: begin
				// A set updates in place, reuses a tombstone, or takes a fresh slot
				// only while the load limit allows it.
				if (found) begin
					tbl_value[hit] = wval;
				end else if (have_free && tbl_state[free_idx] == SLOT_TOMB) begin
					tbl_state[free_idx] = SLOT_USED;
					tbl_key[free_idx] = key;
					tbl_value[free_idx] = wval;
					rsp.new_key = 1'b1;
				end else if (!have_free || 4 * (tbl_used + 1) > 3 * CAPACITY) begin
					rsp.status = ST_FULL;
				end else begin
					tbl_state[free_idx] = SLOT_USED;
					tbl_key[free_idx] = key;
					tbl_value[free_idx] = wval;
					tbl_used++;
					rsp.new_key = 1'b1;
				end
			end
		endcase
		return rsp;
	endfunction

	// Offers one request word, holds it until accepted, then records its response.
	task automatic send_word(req_op_t op, logic [KEY_W-1:0] key, logic [HASH_W-1:0] hash,
			logic [VALUE_W-1:0] wval);
		while ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_type <= op;
		key_id <= key;
		key_hash <= hash;
		write_value <= wval;
		do @(posedge clk); while (req_stall !== 1'b0);
		rsp_owed.push_back(apply_to_table(op, key, hash, wval));
	endtask

	// Mostly pool keys with consistent hashes, some noise with random keys and hashes.
	task automatic send_random_word(int span);
		int                 pick;
		int                 slot;
		req_op_t            op;
		logic [KEY_W-1:0]   key;
		logic [HASH_W-1:0]  hash;

		pick = $urandom_range(999);
		slot = $urandom_range(span - 1);
		key = pool_key[slot];
		hash = pool_hash[slot];
		if (pick < 5) begin
			op = REQ_CLEAR;
		end else if (pick < 420) begin
			op = REQ_SET;
		end else if (pick < 720) begin
			op = REQ_GET;
		end else if (pick < 930) begin
			op = REQ_DEL;
		end else begin
			op = req_op_t'($urandom_range(2));
			key = $urandom;
			hash = (pick < 965) ? $urandom : hash;
		end
		send_word(op, key, hash, {$urandom, $urandom});
	endtask

	// Field extremes, every operation, wrap-around, tombstone reuse and clear.
	task automatic test_directed();
		req_idle_pct = 26;
		rsp_stall_pct <= 26;
		send_word(REQ_GET, '0, '0, '1);
		send_word(REQ_DEL, '1, '1, '0);
		send_word(REQ_SET, '0, '0, '0);
		send_word(REQ_SET, '1, '1, '1);
		send_word(REQ_SET, 32'd1, 32'h0000_00FF, 64'h8000_0000_0000_0001);
		send_word(REQ_GET, 32'd1, 32'h0000_00FF, '0);
		send_word(REQ_SET, '0, '0, 64'hDEAD_BEEF_0123_4567);
		send_word(REQ_GET, '0, '0, '1);
		send_word(REQ_DEL, '1, '1, '1);
		send_word(REQ_GET, 32'd1, 32'h0000_00FF, '0);
		send_word(REQ_GET, '1, '1, '0);
		send_word(REQ_SET, 32'd2, 32'h0000_00FF, 64'h5555_AAAA_5555_AAAA);
		send_word(REQ_GET, 32'd2, 32'h0000_00FF, '0);
		send_word(REQ_DEL, 32'd1, 32'h0000_00FF, '0);
		send_word(REQ_DEL, 32'd1, 32'h0000_00FF, '0);
		send_word(REQ_SET, 32'd1, 32'h0000_00FF, 64'h7FFF_FFFF_FFFF_FFFE);
		send_word(REQ_GET, 32'd1, 32'h0000_00FF, 64'hFFFF_0000_FFFF_0000);
		send_word(REQ_CLEAR, $urandom, $urandom, {$urandom, $urandom});
		send_word(REQ_GET, '0, '0, '0);
		send_word(REQ_SET, '0, '0, 64'h0123_4567_89AB_CDEF);
		send_word(REQ_GET, '0, 32'd1, '0);
	endtask

	// Fills the table to three quarters, then checks refusal and tombstone reuse.
	task automatic test_load_limit();
		logic [KEY_W-1:0]   kept_key  [4];
		logic [HASH_W-1:0]  kept_hash [4];
		logic [KEY_W-1:0]   key;
		logic [HASH_W-1:0]  hash;
		int                 n;

		req_idle_pct = 26;
		rsp_stall_pct <= 26;
		send_word(REQ_CLEAR, $urandom, $urandom, {$urandom, $urandom});
		n = 0;
		while (tbl_used < LOAD_LIMIT) begin
			key = $urandom;
			hash = $urandom;
			if (n < 4) begin
				kept_key[n] = key;
				kept_hash[n] = hash;
			end
			send_word(REQ_SET, key, hash, {$urandom, $urandom});
			n++;
		end

		// New keys are now refused with the full status.
		repeat (4) send_word(REQ_SET, $urandom, $urandom, {$urandom, $urandom});

		// Updates still go through, and a new key passing a tombstone reuses it.
		for (int i = 0; i < 4; i++) begin
			send_word(REQ_GET, kept_key[i], kept_hash[i], {$urandom, $urandom});
			send_word(REQ_SET, kept_key[i], kept_hash[i], {$urandom, $urandom});
			send_word(REQ_DEL, kept_key[i], kept_hash[i], {$urandom, $urandom});
			send_word(REQ_SET, $urandom, kept_hash[i], {$urandom, $urandom});
			send_word(REQ_GET, kept_key[i], kept_hash[i], '0);
		end
	endtask

	// Random traffic over all or part of the key pool under one idling pattern.
	task automatic test_mixed_traffic(int span, int idle_pct, int stall_pct);
		req_idle_pct = idle_pct;
		rsp_stall_pct <= stall_pct;
		send_word(REQ_CLEAR, $urandom, $urandom, {$urandom, $urandom});
		repeat (PHASE_WORDS) send_random_word(span);
	endtask

	// The receiver holds off for a long stretch while requests keep coming.
	task automatic test_backpressure();
		req_idle_pct = 0;
		rsp_stall_pct <= 0;
		hold_trigger <= 1'b1;
		repeat (40) send_random_word(64);
	endtask

	// Response side: random stalls, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (hold_trigger) begin
			hold_trigger <= 1'b0;
			hold_left <= HOLD_CYCLES;
			rsp_stall <= 1'b1;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= ($urandom_range(99) < rsp_stall_pct);
		end
	end

	// Each accepted response word is checked against the oldest owed one.
	always @(posedge clk) begin : check_rsp
		rsp_word_t want;
		if (arst_n && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
			if (rsp_owed.size() == 0) begin
				$display("%0t: unexpected response word: expected none, actual status %0d",
					$time, status);
				errors++;
			end else begin
				want = rsp_owed.pop_front();
				if (status !== want.status) begin
					$display("%0t: status mismatch: expected %0d, actual %0d",
						$time, want.status, status);
					errors++;
				end
				if (new_key !== want.new_key) begin
					$display("%0t: new_key mismatch: expected %0b, actual %0b",
						$time, want.new_key, new_key);
					errors++;
				end
				if (read_value !== want.read_value) begin
					$display("%0t: read_value mismatch: expected %h, actual %h",
						$time, want.read_value, read_value);
					errors++;
				end
			end
		end
	end

	// Ends the run when no word moves on either channel for too long.
	always @(posedge clk) begin
		if (!arst_n || (req_valid && req_stall === 1'b0) ||
				(rsp_valid === 1'b1 && !rsp_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("%0t: timeout, no word accepted for %0d cycles", $time, quiet_cycles);
			$display("testbench: FAIL");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		empty_table();
		// Half the pool crowds into a few slot ranges, one of them wrapping at the end.
		for (int i = 0; i < POOL_SIZE; i++) begin
			pool_key[i] = $urandom;
			pool_hash[i] = $urandom;
			if (i % 2 == 0) begin
				pool_hash[i][7:0] = 8'(8'hF8 * (i % 8 == 0) + 8'h40 * (i % 8 == 2) +
					8'h90 * (i % 8 == 4) + $urandom_range(15));
			end
		end

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed();
		test_load_limit();
		test_mixed_traffic(24, 0, 0);
		test_mixed_traffic(POOL_SIZE, 75, 0);
		test_mixed_traffic(64, 0, 75);
		test_mixed_traffic(POOL_SIZE, 26, 26);
		test_backpressure();

		req_valid <= 1'b0;
		while (rsp_owed.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (errors == 0 && rsp_owed.size() == 0) begin
			$display("testbench: PASS");
		end else begin
			$display("testbench: FAIL");
		end
		$finish;
	end

endmodule
